// ===== design/cpr_pkg.sv =====
package cpr_pkg;

  localparam int MAX_PROCS  = 16;
  localparam int MAX_PAGES  = 1024;
  localparam int PROC_W     = $clog2(MAX_PROCS);
  localparam int PAGE_W     = $clog2(MAX_PAGES);
  localparam int CNT_W      = PAGE_W + 1;
  localparam int ADDR_W     = PROC_W + PAGE_W;
  localparam int MEM_DEPTH  = MAX_PROCS * MAX_PAGES;

  localparam int LOC_W      = 21;
  localparam int LG_W       = 3;
  localparam int LG_MAX     = 5;
  localparam int FRAMES_W   = 10;
  localparam int FRAMES_RST = 32;
  localparam int STATUS_W   = 3;
  localparam int FAULT_W    = 32;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  // register index, taken from paddr[2]
  localparam logic REG_PAGE_SIZE_LOG2     = 1'b0;
  localparam logic REG_FRAMES_PER_PROCESS = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT     = 3'd0,
    ST_FAULT   = 3'd1,
    ST_LOADED  = 3'd2,
    ST_RANGE   = 3'd3,
    ST_NOFRAME = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LOAD,
    S_HIT_CHK,
    S_SWEEP,
    S_FAULT_WR,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic resident;
    logic referenced;
  } entry_t;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    entry_t            wr_data;
  } mem_req_t;

  typedef struct packed {
    logic [LG_W-1:0]     page_size_log2;
    logic [FRAMES_W-1:0] frames_per_process;
  } cfg_t;

endpackage

// ===== design/cpr_in_if.sv =====
interface cpr_in_if;
  import cpr_pkg::*;

  logic              valid;
  logic              ready;
  logic              op;
  logic [PROC_W-1:0] process;
  logic [LOC_W-1:0]  location;

  modport source (output valid, op, process, location, input ready);
  modport sink   (input valid, op, process, location, output ready);
endinterface

// ===== design/cpr_out_if.sv =====
interface cpr_out_if;
  import cpr_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                evicted_valid;
  logic [PAGE_W-1:0]   evicted_page;
  logic [FAULT_W-1:0]  fault_total;

  modport source (output valid, status, evicted_valid, evicted_page, fault_total,
                  input ready);
  modport sink   (input valid, status, evicted_valid, evicted_page, fault_total,
                  output ready);
endinterface

// ===== design/cpr_cfg.sv =====
module cpr_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cpr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [cpr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [cpr_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  output cpr_pkg::cfg_t                  cfg
);
  import cpr_pkg::*;

  logic wr_fire;

  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.page_size_log2     <= '0;
      cfg.frames_per_process <= FRAMES_W'(FRAMES_RST);
    end else if (wr_fire) begin
      unique case (paddr[2])
        REG_PAGE_SIZE_LOG2:     cfg.page_size_log2     <= pwdata[LG_W-1:0];
        REG_FRAMES_PER_PROCESS: cfg.frames_per_process <= pwdata[FRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PAGE_SIZE_LOG2:     prdata = APB_DATA_W'(cfg.page_size_log2);
      REG_FRAMES_PER_PROCESS: prdata = APB_DATA_W'(cfg.frames_per_process);
      default:                prdata = '0;
    endcase
  end

endmodule

// ===== design/cpr_page_ram.sv =====
module cpr_page_ram (
  input  logic              clk,
  input  cpr_pkg::mem_req_t mreq,
  output cpr_pkg::entry_t   rdata
);
  import cpr_pkg::*;

  entry_t mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (mreq.wr_en) begin
      mem[mreq.wr_addr] <= mreq.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mreq.rd_en) begin
      rdata <= mem[mreq.rd_addr];
    end
  end

endmodule

// ===== design/cpr_ctrl.sv =====
module cpr_ctrl (
  input  logic              clk,
  input  logic              rst,
  cpr_in_if.sink            req,
  cpr_out_if.source         rsp,
  input  cpr_pkg::cfg_t     cfg,
  output cpr_pkg::mem_req_t mreq,
  input  cpr_pkg::entry_t   rdata
);
  import cpr_pkg::*;

  ctrl_state_t state, state_next;

  logic              op_r;
  logic [PROC_W-1:0] proc_r;
  logic [LOC_W-1:0]  loc_r;
  logic [PAGE_W-1:0] pg_r;
  logic [PAGE_W-1:0] hand_r;
  logic [PAGE_W-1:0] victim;
  logic [CNT_W-1:0]  idx;
  status_t           res_status;
  logic [FAULT_W-1:0] fault_cnt;

  logic [CNT_W-1:0]  page_cnt [MAX_PROCS];
  logic [PAGE_W-1:0] hand_pos [MAX_PROCS];
  logic [CNT_W-1:0]  res_cnt  [MAX_PROCS];

  logic                out_valid;
  status_t             out_status;
  logic                out_ev;
  logic [PAGE_W-1:0]   out_page;
  logic [FAULT_W-1:0]  out_total;

  logic [LG_W-1:0]   lg_eff;
  logic [LOC_W:0]    round_sum;
  logic [LOC_W:0]    load_pages;
  logic              load_over;
  logic [CNT_W-1:0]  load_cnt;
  logic [CNT_W-1:0]  frames_ext;
  logic [CNT_W-1:0]  frames_eff;
  logic [LOC_W-1:0]  loc_m1;
  logic [LOC_W-1:0]  acc_pages;
  logic              acc_bad;
  logic [CNT_W-1:0]  cur_cnt;
  logic [PAGE_W-1:0] hand_start;
  logic [PAGE_W-1:0] hand_adv;
  logic              idx_last;
  logic              out_free;
  logic              skip;
  logic              no_frame;

  assign lg_eff     = (cfg.page_size_log2 > LG_W'(LG_MAX)) ? LG_W'(LG_MAX)
                                                             : cfg.page_size_log2;
  assign round_sum  = {1'b0, loc_r} + (((LOC_W+1)'(1)) << lg_eff) - (LOC_W+1)'(1);
  assign load_pages = round_sum >> lg_eff;
  assign load_over  = load_pages > (LOC_W+1)'(MAX_PAGES);
  assign load_cnt   = load_pages[CNT_W-1:0];
  assign frames_ext = CNT_W'(cfg.frames_per_process);
  assign frames_eff = (frames_ext < load_cnt) ? frames_ext : load_cnt;

  assign cur_cnt    = page_cnt[proc_r];
  assign loc_m1     = loc_r - LOC_W'(1);
  assign acc_pages  = loc_m1 >> lg_eff;
  assign acc_bad    = (loc_r == '0) || (acc_pages >= LOC_W'(cur_cnt));

  assign hand_start = (CNT_W'(hand_pos[proc_r]) >= cur_cnt) ? '0 : hand_pos[proc_r];
  assign hand_adv   = ((CNT_W'(hand_r) + CNT_W'(1)) == cur_cnt) ? '0
                                                                 : hand_r + PAGE_W'(1);
  assign idx_last   = (idx + CNT_W'(1)) == cur_cnt;
  assign out_free   = !out_valid || rsp.ready;
  assign skip       = rdata.referenced || !rdata.resident;
  assign no_frame   = res_cnt[proc_r] == '0;

  assign req.ready         = (state == S_IDLE);
  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.evicted_valid = out_ev;
  assign rsp.evicted_page  = out_page;
  assign rsp.fault_total   = out_total;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (req.valid) state_next = S_DECODE;
      S_DECODE: begin
        if (op_r == OP_LOAD) begin
          state_next = (load_over || load_cnt == '0) ? S_DONE : S_LOAD;
        end else begin
          state_next = acc_bad ? S_DONE : S_HIT_CHK;
        end
      end
      S_LOAD:     if (idx_last) state_next = S_DONE;
      S_HIT_CHK:  state_next = (rdata.resident || no_frame) ? S_DONE : S_SWEEP;
      S_SWEEP:    if (!skip) state_next = S_FAULT_WR;
      S_FAULT_WR: state_next = S_DONE;
      S_DONE:     if (out_free) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // page RAM requests
  always_comb begin
    mreq = '0;
    unique case (state)
      S_DECODE: begin
        if (op_r == OP_ACCESS && !acc_bad) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = {proc_r, acc_pages[PAGE_W-1:0]};
        end
      end
      S_LOAD: begin
        mreq.wr_en                = 1'b1;
        mreq.wr_addr              = {proc_r, idx[PAGE_W-1:0]};
        mreq.wr_data.resident     = idx < res_cnt[proc_r];
        mreq.wr_data.referenced   = idx < res_cnt[proc_r];
      end
      S_HIT_CHK: begin
        if (rdata.resident) begin
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = {proc_r, pg_r};
          mreq.wr_data = '{resident: 1'b1, referenced: 1'b1};
        end else if (!no_frame) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = {proc_r, hand_start};
        end
      end
      S_SWEEP: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = {proc_r, hand_r};
        if (skip) begin
          // second chance: drop the reference bit, move to the next page
          mreq.wr_data = '{resident: rdata.resident, referenced: 1'b0};
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = {proc_r, hand_adv};
        end else begin
          mreq.wr_data = '{resident: 1'b0, referenced: 1'b0};
        end
      end
      S_FAULT_WR: begin
        mreq.wr_en   = 1'b1;
        mreq.wr_addr = {proc_r, pg_r};
        mreq.wr_data = '{resident: 1'b1, referenced: 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      fault_cnt <= '0;
      for (int i = 0; i < MAX_PROCS; i++) begin
        page_cnt[i] <= '0;
        hand_pos[i] <= '0;
        res_cnt[i]  <= '0;
      end
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          op_r   <= req.op;
          proc_r <= req.process;
          loc_r  <= req.location;
        end
        S_DECODE: begin
          if (op_r == OP_LOAD) begin
            if (load_over) begin
              res_status <= ST_RANGE;
            end else begin
              page_cnt[proc_r] <= load_cnt;
              hand_pos[proc_r] <= '0;
              res_cnt[proc_r]  <= frames_eff;
              res_status       <= ST_LOADED;
            end
            idx <= '0;
          end else begin
            pg_r       <= acc_pages[PAGE_W-1:0];
            res_status <= acc_bad ? ST_RANGE : ST_HIT;
          end
        end
        S_LOAD:  idx <= idx + CNT_W'(1);
        S_HIT_CHK: begin
          if (!rdata.resident) begin
            res_status <= no_frame ? ST_NOFRAME : ST_FAULT;
            hand_r     <= hand_start;
          end
        end
        S_SWEEP: begin
          if (skip) hand_r <= hand_adv;
          else      victim <= hand_r;
        end
        S_FAULT_WR: begin
          hand_pos[proc_r] <= hand_adv;
          fault_cnt        <= fault_cnt + FAULT_W'(1);
        end
        S_DONE: begin
          if (out_free) begin
            out_status <= res_status;
            out_ev     <= res_status == ST_FAULT;
            out_page   <= (res_status == ST_FAULT) ? victim : '0;
            out_total  <= fault_cnt;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== design/clock_page_replacement.sv =====
// Channel  Interface          Dir  Payload
// req      cpr_in_if.sink     in   op, process, location
// rsp      cpr_out_if.source  out  status, evicted_valid, evicted_page, fault_total
// cfg      APB                in   page_size_log2 @ 0x0, frames_per_process @ 0x4
//
// The page RAM, with one read and one write port, sets the pace: the load writes one page
// per cycle, the clock sweep reads one page and writes one back per cycle. A refused load
// reports a range error; on a fault the hand visits under twice the page count.
// Reset (rst, synchronous) clears page counts, hands and the fault counter; the RAM is
// not cleared, since no page of a process is read before a load writes it.
// One item is in flight; the next is taken while its result still waits on rsp.

module clock_page_replacement (
  input  logic                           clk,
  input  logic                           rst,
  cpr_in_if.sink                         req,
  cpr_out_if.source                      rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cpr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [cpr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [cpr_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import cpr_pkg::*;

  cfg_t     cfg;
  mem_req_t mreq;
  entry_t   rdata;

  // configuration registers
  cpr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: decode, load, hit check, clock sweep, result register
  cpr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rsp   (rsp),
    .cfg   (cfg),
    .mreq  (mreq),
    .rdata (rdata)
  );

  // resident and reference bits of every page of every process
  cpr_page_ram u_ram (
    .clk   (clk),
    .mreq  (mreq),
    .rdata (rdata)
  );

  // the sweep writes one page and reads the next; they never coincide
  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    mreq.rd_en && mreq.wr_en |-> mreq.rd_addr != mreq.wr_addr)
    else $error("page RAM read and write hit the same entry");

  // after a transfer in, no further item is taken until the work is done
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("second item taken while one is in flight");

  // the page RAM is only written while an item is being worked on
  a_wr_only_busy: assert property (@(posedge clk) disable iff (rst)
    mreq.wr_en |-> !req.ready)
    else $error("page RAM written while idle");

endmodule
